>>> design/cdc_pkg.sv
`default_nettype none

package cdc_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int DAY_COUNT_W = 16;
    localparam int CNT_W       = (COUNT_BITS < DAY_COUNT_W) ? COUNT_BITS : DAY_COUNT_W;
    localparam int CMP_W       = (CNT_W > 6) ? CNT_W : 6;

    localparam int OP_W      = 3;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int YEAR_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [YEAR_W-1:0]  YEAR_TOP      = 12'd4095;
    localparam logic [YEAR_W-1:0]  RESET_YEAR    = 12'd1900;
    localparam logic [YEAR_W-1:0]  MIN_YEAR_RST  = 12'd1900;
    localparam logic [YEAR_W-1:0]  MAX_YEAR_RST  = 12'd2100;
    localparam logic [MONTH_W-1:0] JAN           = 4'd1;
    localparam logic [MONTH_W-1:0] FEB           = 4'd2;
    localparam logic [MONTH_W-1:0] DEC           = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_ONE       = 5'd1;
    localparam logic [DAY_W-1:0]   LEAP_FEB_LEN  = 5'd29;
    localparam logic [DAY_W-1:0]   LAST_DEC_DAY  = 5'd31;

    // Month lengths indexed by month; codes outside 1 to 12 read as 31.
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 3'd0,
        OP_NEXT = 3'd1,
        OP_PREV = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_MONTH = 2'd1,
        STAT_BAD_YEAR  = 2'd2,
        STAT_BAD_DAY   = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // The quotient by 100 comes from a reciprocal multiply, exact for 12-bit years.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [24:0]       prod;
        logic [5:0]        q;
        logic [YEAR_W-1:0] q100;
        logic              div100;
        prod   = 25'(y) * 25'(5243);
        q      = prod[24:19];
        q100   = YEAR_W'({q, 6'b0}) + YEAR_W'({q, 5'b0}) + YEAR_W'({q, 2'b0});
        div100 = (q100 == y);
        return (y[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[m];
        if (m == FEB && is_leap(y))
        begin
            len = LEAP_FEB_LEN;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> design/cdc_ifs.sv
`default_nettype none

interface cdc_in_if;
    import cdc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [MONTH_W-1:0]     new_month;
    logic [DAY_W-1:0]       new_day;
    logic [YEAR_W-1:0]      new_year;
    logic [DAY_COUNT_W-1:0] day_count;

    modport source (output valid, operation, new_month, new_day, new_year, day_count,
                    input ready);
    modport sink (input valid, operation, new_month, new_day, new_year, day_count,
                  output ready);
endinterface

interface cdc_out_if;
    import cdc_pkg::*;

    logic                valid;
    logic                ready;
    logic [MONTH_W-1:0]  cur_month;
    logic [DAY_W-1:0]    cur_day;
    logic [YEAR_W-1:0]   cur_year;
    logic [STATUS_W-1:0] status;

    modport source (output valid, cur_month, cur_day, cur_year, status, input ready);
    modport sink (input valid, cur_month, cur_day, cur_year, status, output ready);
endinterface

interface cdc_cfg_if;
    import cdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [YEAR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/cdc_load_check.sv
`default_nettype none

module cdc_load_check (
    input  cdc_pkg::date_t             ld_date,
    input  logic [cdc_pkg::YEAR_W-1:0] min_year,
    input  logic [cdc_pkg::YEAR_W-1:0] max_year,
    output cdc_pkg::status_t           status
);
    import cdc_pkg::*;

    // Month first, then year, then day: the first failing check wins.
    always_comb
    begin
        if (ld_date.month < JAN || ld_date.month > DEC)
        begin
            status = STAT_BAD_MONTH;
        end
        else if (ld_date.year < min_year || ld_date.year > max_year)
        begin
            status = STAT_BAD_YEAR;
        end
        else if (ld_date.day == '0 || ld_date.day > days_in(ld_date.month, ld_date.year))
        begin
            status = STAT_BAD_DAY;
        end
        else
        begin
            status = STAT_OK;
        end
    end

endmodule

`default_nettype wire

>>> design/cdc_step_unit.sv
`default_nettype none

module cdc_step_unit (
    input  cdc_pkg::date_t            cur,
    input  logic                      fwd,
    input  logic [cdc_pkg::CNT_W-1:0] n,
    output cdc_pkg::date_t            nxt,
    output logic [cdc_pkg::CNT_W-1:0] n_next,
    output logic                      fin
);
    import cdc_pkg::*;

    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   rem;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;
    logic [DAY_W-1:0]   prev_len;
    logic [CMP_W-1:0]   n_wide;

    // One pass moves the date by at most one month boundary.
    always_comb
    begin
        len        = days_in(cur.month, cur.year);
        rem        = (cur.day < len) ? (len - cur.day) : '0;
        prev_month = (cur.month > JAN) ? (cur.month - MONTH_W'(1)) : DEC;
        prev_year  = (cur.month > JAN) ? cur.year : (cur.year - YEAR_W'(1));
        prev_len   = days_in(prev_month, prev_year);
        n_wide     = CMP_W'(n);

        nxt    = cur;
        n_next = n;
        fin    = 1'b0;

        if (n == '0)
        begin
            fin = 1'b1;
        end
        else if (fwd)
        begin
            if (n_wide <= CMP_W'(rem))
            begin
                nxt.day = cur.day + DAY_W'(n);
                fin     = 1'b1;
            end
            else if (cur.month >= DEC && cur.year >= YEAR_TOP)
            begin
                nxt.month = DEC;
                nxt.day   = LAST_DEC_DAY;
                fin       = 1'b1;
            end
            else
            begin
                n_next  = CNT_W'(n_wide - CMP_W'(rem) - CMP_W'(1));
                nxt.day = DAY_ONE;
                if (cur.month < DEC)
                begin
                    nxt.month = cur.month + MONTH_W'(1);
                end
                else
                begin
                    nxt.month = JAN;
                    nxt.year  = cur.year + YEAR_W'(1);
                end
                fin = (n_next == '0);
            end
        end
        else
        begin
            if (n_wide < CMP_W'(cur.day))
            begin
                nxt.day = cur.day - DAY_W'(n);
                fin     = 1'b1;
            end
            else if (cur.month <= JAN && cur.year == '0)
            begin
                nxt.month = JAN;
                nxt.day   = DAY_ONE;
                fin       = 1'b1;
            end
            else
            begin
                n_next    = CNT_W'(n_wide - CMP_W'(cur.day));
                nxt.month = prev_month;
                nxt.year  = prev_year;
                nxt.day   = prev_len;
                fin       = (n_next == '0);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/cdc_ctrl.sv
`default_nettype none

module cdc_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [cdc_pkg::YEAR_W-1:0] min_year,
    input  logic [cdc_pkg::YEAR_W-1:0] max_year,
    cdc_in_if.sink                     in_ch,
    cdc_out_if.source                  out_ch
);
    import cdc_pkg::*;

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    date_t            date_reg;
    date_t            date_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [OP_W-1:0]  op_reg;
    date_t            ld_date_reg;
    logic             out_valid_reg;
    date_t            out_date_reg;
    status_t          out_status_reg;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic [CNT_W-1:0] start_n;
    logic             fwd;
    status_t          ld_status;
    date_t            unit_date;
    logic [CNT_W-1:0] unit_n_next;
    logic             unit_fin;
    date_t            res_date;
    logic             res_fin;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign fwd      = (op_reg == OP_NEXT) || (op_reg == OP_ADD);

    always_comb
    begin
        case (in_ch.operation)
            OP_NEXT, OP_PREV: start_n = CNT_W'(1);
            OP_ADD, OP_SUB:   start_n = in_ch.day_count[CNT_W-1:0];
            default:          start_n = '0;
        endcase
    end

    cdc_load_check u_load_check (
        .ld_date  (ld_date_reg),
        .min_year (min_year),
        .max_year (max_year),
        .status   (ld_status)
    );

    cdc_step_unit u_step_unit (
        .cur    (date_reg),
        .fwd    (fwd),
        .n      (n_reg),
        .nxt    (unit_date),
        .n_next (unit_n_next),
        .fin    (unit_fin)
    );

    always_comb
    begin
        if (op_reg == OP_LOAD)
        begin
            res_date = (ld_status == STAT_OK) ? ld_date_reg : date_reg;
            res_fin  = 1'b1;
        end
        else
        begin
            res_date = unit_date;
            res_fin  = unit_fin;
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The final pass is held while the previous result is still waiting.
    always_comb
    begin
        state_next = state_reg;
        date_next  = date_reg;
        n_next     = n_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (!res_fin)
                begin
                    date_next = res_date;
                    n_next    = unit_n_next;
                end
                else if (out_free)
                begin
                    date_next  = res_date;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.month <= JAN;
            date_reg.day   <= DAY_ONE;
            date_reg.year  <= RESET_YEAR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            date_reg <= date_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg             <= start_n;
            op_reg            <= in_ch.operation;
            ld_date_reg.month <= in_ch.new_month;
            ld_date_reg.day   <= in_ch.new_day;
            ld_date_reg.year  <= in_ch.new_year;
        end
        else
        begin
            n_reg <= n_next;
        end
        if (out_load)
        begin
            out_date_reg   <= res_date;
            out_status_reg <= (op_reg == OP_LOAD) ? ld_status : STAT_OK;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.cur_month = out_date_reg.month;
    assign out_ch.cur_day   = out_date_reg.day;
    assign out_ch.cur_year  = out_date_reg.year;
    assign out_ch.status    = out_status_reg;

    a_date_legal : assert property (@(posedge clk) disable iff (!rst_n)
        (date_reg.month >= JAN) && (date_reg.month <= DEC) && (date_reg.day != '0))
        else $error("held date has an illegal month or day");

    a_idle_holds_date : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> (date_reg == $past(date_reg)))
        else $error("date changed while no item was in work");

    a_bad_load_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY && op_reg == OP_LOAD && ld_status != STAT_OK)
        |=> $stable(date_reg))
        else $error("rejected load changed the date");

    a_finish_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("finished item produced no result");

endmodule

`default_nettype wire

>>> design/calendar_date_counter_core.sv
// A load, a one-day step, a zero count or an unused code finishes in a single pass of
// the month-stepping unit; a count step repeats passes, crossing at most one month
// boundary in each, until its count is used up. The last pass waits while the output
// register still holds an unaccepted result. Throughput: one item at a time; the next
// item is taken once the last pass of the month-stepping unit has handed its result
// to the output register. Reset: date 1 January 1900, year limits 1900 to 2100.
`default_nettype none

module calendar_date_counter_core (
    input  logic      clk,
    input  logic      rst_n,
    cdc_in_if.sink    in_ch,
    cdc_out_if.source out_ch,
    cdc_cfg_if.sink   cfg
);
    import cdc_pkg::*;

    logic [YEAR_W-1:0] min_year_reg;
    logic [YEAR_W-1:0] max_year_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= MIN_YEAR_RST;
            max_year_reg <= MAX_YEAR_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MIN_YEAR: min_year_reg <= cfg.data;
                REG_MAX_YEAR: max_year_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    cdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .min_year (min_year_reg),
        .max_year (max_year_reg),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

>>> tb/date_checker.sv
`timescale 1ns / 1ps

module date_checker
    import cdc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cdc_in_if    in_ch,
    cdc_out_if   out_ch,
    cdc_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding,
    output int   results_checked
);

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        status_t            status;
    } dated_result_t;

    dated_result_t      expected_dates [$];
    logic [MONTH_W-1:0] month_now;
    logic [DAY_W-1:0]   day_now;
    logic [YEAR_W-1:0]  year_now;
    logic [YEAR_W-1:0]  min_year_lim;
    logic [YEAR_W-1:0]  max_year_lim;

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned len;
        if (m == FEB)
        begin
            len = leap_year(y) ? 29 : 28;
        end
        else if (m == 4 || m == 6 || m == 9 || m == 11)
        begin
            len = 30;
        end
        else
        begin
            len = 31;
        end
        return len;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic step_forward_days(input int unsigned n);
        int unsigned len;
        int unsigned rem;
        while (n > 0)
        begin
            len = month_days(month_now, year_now);
            rem = (day_now < len) ? len - day_now : 0;
            if (n <= rem)
            begin
                day_now = day_now + DAY_W'(n);
                n = 0;
            end
            else if (month_now >= DEC && year_now >= YEAR_TOP)
            begin
                // Pinned at the last representable day.
                month_now = DEC;
                day_now   = LAST_DEC_DAY;
                n         = 0;
            end
            else
            begin
                n       = n - rem - 1;
                day_now = DAY_ONE;
                if (month_now < DEC)
                begin
                    month_now = month_now + 1'b1;
                end
                else
                begin
                    month_now = JAN;
                    year_now  = year_now + 1'b1;
                end
            end
        end
    endtask

    task automatic step_back_days(input int unsigned n);
        while (n > 0)
        begin
            if (n < day_now)
            begin
                day_now = day_now - DAY_W'(n);
                n = 0;
            end
            else if (month_now <= JAN && year_now == 0)
            begin
                month_now = JAN;
                day_now   = DAY_ONE;
                n         = 0;
            end
            else
            begin
                n = n - day_now;
                if (month_now > JAN)
                begin
                    month_now = month_now - 1'b1;
                end
                else
                begin
                    month_now = DEC;
                    year_now  = year_now - 1'b1;
                end
                day_now = DAY_W'(month_days(month_now, year_now));
            end
        end
    endtask

    task automatic predict_date(input logic [OP_W-1:0] op, input logic [MONTH_W-1:0] m,
                                input logic [DAY_W-1:0] d, input logic [YEAR_W-1:0] y,
                                input logic [DAY_COUNT_W-1:0] cnt);
        dated_result_t res;
        status_t       st;
        int unsigned   days;
        st   = STAT_OK;
        days = int'(cnt[CNT_W-1:0]);
        case (op)
            OP_LOAD:
            begin
                // Month first, then year, then day; any failure keeps the old date.
                if (m < JAN || m > DEC)
                begin
                    st = STAT_BAD_MONTH;
                end
                else if (y < min_year_lim || y > max_year_lim)
                begin
                    st = STAT_BAD_YEAR;
                end
                else if (d < DAY_ONE || d > month_days(m, y))
                begin
                    st = STAT_BAD_DAY;
                end
                else
                begin
                    month_now = m;
                    day_now   = d;
                    year_now  = y;
                end
            end
            OP_NEXT: step_forward_days(1);
            OP_PREV: step_back_days(1);
            OP_ADD:  step_forward_days(days);
            OP_SUB:  step_back_days(days);
            default: ;
        endcase
        res.month  = month_now;
        res.day    = day_now;
        res.year   = year_now;
        res.status = st;
        expected_dates.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dated_result_t want;
        if (!rst_n)
        begin
            expected_dates.delete();
            month_now       = JAN;
            day_now         = DAY_ONE;
            year_now        = RESET_YEAR;
            min_year_lim    = MIN_YEAR_RST;
            max_year_lim    = MAX_YEAR_RST;
            mismatches      = 0;
            results_checked = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_MIN_YEAR)
                begin
                    min_year_lim = cfg.data;
                end
                else if (cfg.index == REG_MAX_YEAR)
                begin
                    max_year_lim = cfg.data;
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_dates.size() == 0)
                begin
                    note_mismatch("result with nothing expected, month", out_ch.cur_month, 0);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (out_ch.cur_month !== want.month)
                    begin
                        note_mismatch("cur_month", out_ch.cur_month, want.month);
                    end
                    if (out_ch.cur_day !== want.day)
                    begin
                        note_mismatch("cur_day", out_ch.cur_day, want.day);
                    end
                    if (out_ch.cur_year !== want.year)
                    begin
                        note_mismatch("cur_year", out_ch.cur_year, want.year);
                    end
                    if (out_ch.status !== want.status)
                    begin
                        note_mismatch("status", out_ch.status, want.status);
                    end
                    results_checked++;
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predict_date(in_ch.operation, in_ch.new_month, in_ch.new_day,
                             in_ch.new_year, in_ch.day_count);
            end
            outstanding <= expected_dates.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cdc_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int              PHASES      = 6;
    localparam int              PHASE_ITEMS = 330;
    localparam int              HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    cdc_in_if  in_ch ();
    cdc_out_if out_ch ();
    cdc_cfg_if cfg ();

    int mismatches;
    int outstanding;
    int results_checked;

    int idle_pct;
    int stall_pct;
    int hold_asks;
    int items_sent;
    int limit_settings;

    calendar_date_counter_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    date_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg             (cfg),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("FAIL calendar_date_counter_core");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Leaves valid high after the handshake so back-to-back items need no gap.
    task automatic offer_item(input logic [OP_W-1:0] op, input logic [MONTH_W-1:0] m,
                              input logic [DAY_W-1:0] d, input logic [YEAR_W-1:0] y,
                              input logic [DAY_COUNT_W-1:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.new_month <= m;
        in_ch.new_day   <= d;
        in_ch.new_year  <= y;
        in_ch.day_count <= cnt;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [YEAR_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_year_limits(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
        write_reg(REG_MIN_YEAR, lo);
        write_reg(REG_MAX_YEAR, hi);
        cfg.valid <= 1'b0;
        @(posedge clk);
        limit_settings++;
    endtask

    // Mostly short counts; a few reach the full field so its top bits toggle.
    function automatic logic [DAY_COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 88)
        begin
            return DAY_COUNT_W'($urandom_range(40));
        end
        else if (r < 98)
        begin
            return DAY_COUNT_W'($urandom_range(1200));
        end
        return DAY_COUNT_W'($urandom_range(65535));
    endfunction

    task automatic send_random_item(input int lo, input int hi);
        int                     r;
        logic [OP_W-1:0]        op;
        logic [MONTH_W-1:0]     m;
        logic [DAY_W-1:0]       d;
        logic [YEAR_W-1:0]      y;
        logic [DAY_COUNT_W-1:0] cnt;
        r   = $urandom_range(99);
        m   = MONTH_W'($urandom_range(15));
        d   = DAY_W'($urandom_range(31));
        y   = YEAR_W'($urandom_range(4095));
        cnt = DAY_COUNT_W'($urandom_range(65535));
        if (r < 25)
        begin
            op = OP_LOAD;
            if ($urandom_range(3) != 0)
            begin
                // Plausible date, inside the limits when they are ordered, often near the end of a month.
                m = MONTH_W'($urandom_range(12, 1));
                d = ($urandom_range(9) < 3) ? DAY_W'($urandom_range(31, 28))
                                            : DAY_W'($urandom_range(28, 1));
                if (lo <= hi)
                begin
                    y = YEAR_W'($urandom_range(hi, lo));
                end
            end
        end
        else if (r < 45)
        begin
            op = OP_NEXT;
        end
        else if (r < 65)
        begin
            op = OP_PREV;
        end
        else if (r < 78)
        begin
            op  = OP_ADD;
            cnt = pick_count();
        end
        else if (r < 91)
        begin
            op  = OP_SUB;
            cnt = pick_count();
        end
        else if (r < 96)
        begin
            op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        else
        begin
            op = OP_W'($urandom_range(7));
            if (op == OP_ADD || op == OP_SUB)
            begin
                cnt = pick_count();
            end
        end
        offer_item(op, m, d, y, cnt);
    endtask

    initial
    begin
        int lo_tab    [PHASES] = '{1900, 0, 2000, 3000, 4000, 0};
        int hi_tab    [PHASES] = '{2100, 4095, 2000, 100, 4095, 120};
        int idle_tab  [PHASES] = '{0, 61, 0, 10, 0, 61};
        int stall_tab [PHASES] = '{0, 0, 61, 10, 0, 0};
        rst_n           = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        hold_asks       = 0;
        items_sent      = 0;
        limit_settings  = 1;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_LOAD;
        in_ch.new_month <= '0;
        in_ch.new_day   <= '0;
        in_ch.new_year  <= '0;
        in_ch.day_count <= '0;
        cfg.valid       <= 1'b0;
        cfg.index       <= REG_MIN_YEAR;
        cfg.data        <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load checks under the reset limits, in check order, then steps, zero counts and unused codes.
        offer_item(OP_LOAD, 4'd0, 5'd15, 12'd2000, '0);
        offer_item(OP_LOAD, 4'd15, 5'd31, 12'd4095, '1);
        offer_item(OP_LOAD, 4'd13, 5'd0, 12'd0, '0);
        offer_item(OP_LOAD, FEB, 5'd29, 12'd1899, '0);
        offer_item(OP_LOAD, FEB, 5'd29, 12'd2101, '0);
        offer_item(OP_LOAD, FEB, 5'd29, 12'd1900, '0);
        offer_item(OP_LOAD, FEB, 5'd29, 12'd2000, '0);
        offer_item(OP_LOAD, 4'd4, 5'd31, 12'd2000, '0);
        offer_item(OP_LOAD, 4'd6, 5'd0, 12'd2000, '0);
        offer_item(OP_NEXT, '0, '0, '0, '0);
        offer_item(OP_PREV, '0, '0, '0, '0);
        offer_item(OP_ADD, '0, '0, '0, '0);
        offer_item(OP_SUB, '0, '0, '0, '0);
        offer_item(OP_LOAD, DEC, LAST_DEC_DAY, 12'd2099, '0);
        offer_item(OP_NEXT, '0, '0, '0, '0);
        offer_item(OP_PREV, '0, '0, '0, '0);
        offer_item(OP_SPARE_LO, '1, '1, '1, '1);
        offer_item(3'd6, '0, '0, '0, '0);
        offer_item(OP_SPARE_HI, '1, '1, '1, '1);
        offer_item(OP_ADD, '0, '0, '0, 16'd366);
        wait_drained();

        // Widest limits: saturation at both ends of the year field, and leap-day loads in century years.
        set_year_limits(12'd0, YEAR_TOP);
        offer_item(OP_LOAD, DEC, LAST_DEC_DAY, YEAR_TOP, '0);
        offer_item(OP_NEXT, '0, '0, '0, '0);
        offer_item(OP_ADD, '0, '0, '0, 16'hFFFF);
        offer_item(OP_LOAD, FEB, 5'd29, 12'd0, '0);
        offer_item(OP_LOAD, FEB, 5'd29, 12'd100, '0);
        offer_item(OP_LOAD, FEB, 5'd29, 12'd400, '0);
        offer_item(OP_LOAD, JAN, DAY_ONE, 12'd0, '0);
        offer_item(OP_PREV, '0, '0, '0, '0);
        offer_item(OP_SUB, '0, '0, '0, 16'hFFFF);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            set_year_limits(YEAR_W'(lo_tab[p]), YEAR_W'(hi_tab[p]));
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // In the fifth phase the result side holds off while items keep coming.
                if (p == 4 && (i == 40 || i == 200))
                begin
                    hold_asks++;
                end
                send_random_item(lo_tab[p], hi_tab[p]);
            end
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (20) @(posedge clk);
        $display("Ran %0d items and checked %0d results under %0d year-limit settings,",
                 items_sent, results_checked, limit_settings);
        $display("with idle and stall mixes, two long result hold-offs and both saturation ends.");
        if (mismatches == 0)
        begin
            $display("PASS calendar_date_counter_core");
        end
        else
        begin
            $display("FAIL calendar_date_counter_core");
        end
        $finish;
    end

endmodule
